// ----- hdl/mmf_pkg.sv -----
package mmf_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int COUNT_W    = 9;
    localparam int CAP_MIN    = 16;
    localparam int BODY_LIMIT = 64;
    localparam int REG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] CAP_RESET    = 9'd256;
    localparam logic [LEN_W-1:0]   MAXMSG_RESET = 7'd64;

    typedef enum logic [1:0] {
        MODE_SEND_BEGIN = 2'd0,
        MODE_SEND_DATA  = 2'd1,
        MODE_RECEIVE    = 2'd2,
        MODE_PEEK       = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_CLOSED  = 3'd2,
        ST_TOO_BIG = 3'd3,
        ST_RETRY   = 3'd4,
        ST_EMPTY   = 3'd5,
        ST_IGNORED = 3'd6
    } t_status;

    typedef struct packed {
        logic                channel_open;
        logic [COUNT_W-1:0]  capacity;
        logic [LEN_W-1:0]    max_message;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_in;
        logic    hdr_start;
        logic    hdr_write;
        logic    data_write;
        logic    rd_start;
        logic    rd_step;
        logic    rd_jump;
        logic    cap_len;
        logic    cap_snd;
        logic    cap_flg;
        logic    consume;
        logic    cnt_clr;
        logic    emit_status;
        logic    emit_data;
        logic    rp_load;
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_mode mode;
        logic  pend_active;
        logic  len_zero;
        logic  closed;
        logic  len_too_big;
        logic  no_space;
        logic  maxs_zero;
        logic  no_header;
        logic  body_too_big;
        logic  hdr_last;
        logic  body_last;
        logic  body_empty;
        logic  slot_free;
    } t_stat;

endpackage

// ----- hdl/mmf_if.sv -----
interface mmf_in_if;
    import mmf_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [BYTE_W-1:0]   length;
    logic [BYTE_W-1:0]   sender_id;
    logic [BYTE_W-1:0]   msg_flags;
    logic [BYTE_W-1:0]   data_byte;
    logic [BYTE_W-1:0]   recv_limit;

    modport source (
        output valid, mode, length, sender_id, msg_flags, data_byte, recv_limit,
        input  ready
    );
    modport sink (
        input  valid, mode, length, sender_id, msg_flags, data_byte, recv_limit,
        output ready
    );
endinterface

interface mmf_out_if;
    import mmf_pkg::*;

    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [BYTE_W-1:0]   data_out;
    logic [LEN_W-1:0]    message_length;
    logic [BYTE_W-1:0]   sender_out;
    logic [BYTE_W-1:0]   flags_out;
    logic                last;
    logic                read_ready;
    logic                write_ready;
    logic [COUNT_W-1:0]  used_bytes;

    modport source (
        output valid, status, data_out, message_length, sender_out, flags_out, last,
               read_ready, write_ready, used_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, data_out, message_length, sender_out, flags_out, last,
               read_ready, write_ready, used_bytes,
        output ready
    );
endinterface

// ----- hdl/message_mailbox_fifo.sv -----
// Channel  Direction  Handshake              Contents
// i_in     in         valid / ready          mode, length, sender_id, msg_flags,
//                                            data_byte, recv_limit
// o_out    out        valid / ready          status, data_out, message_length,
//                                            sender_out, flags_out, last,
//                                            read_ready, write_ready, used_bytes
// APB      in         psel, penable / pready channel_open 0x0, capacity 0x4,
//                                            max_message 0x8
//
// One request is worked at a time. Send data, an ignored request and a request
// rejected on its first checks go through the check and response states only;
// an admitted send begin also writes the header, one header byte per cycle.
// Receive and peek read the header and then the body; the single registered
// read port of the ring yields one body byte at a time, with a wait state
// between bytes. A receive or peek whose body is over the caller's limit is
// turned away after the header read, before any body byte is delivered.
// Reset is synchronous and active low; it clears pointers, counts and the
// open send, and leaves the ring contents as they are, with no clearing pass.
// A result waits in the output register while o_out.ready is low; the
// controller holds its position and takes the next request only when done.
module message_mailbox_fifo #(
    parameter int BUFFER_BYTES = 256,
    parameter int HEADER_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mmf_in_if.sink                            i_in,
    mmf_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mmf_pkg::REG_ADDR_W-1:0]    paddr,
    input  logic [mmf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mmf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mmf_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_flush;
    logic  w_in_ready;

    mmf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_flush (w_flush)
    );

    mmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mmf_dp #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_flush    (w_flush),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in_ready (w_in_ready),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule

// ----- hdl/mmf_regs.sv -----
module mmf_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mmf_pkg::REG_ADDR_W-1:0]    paddr,
    input  logic [mmf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mmf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output mmf_pkg::t_cfg                     o_cfg,
    output logic                              o_flush
);
    import mmf_pkg::*;

    localparam logic [1:0] REG_CHANNEL_OPEN = 2'd0;
    localparam logic [1:0] REG_CAPACITY     = 2'd1;
    localparam logic [1:0] REG_MAX_MESSAGE  = 2'd2;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[3:2];

    // A capacity write empties the ring in the same cycle.
    assign o_flush = w_wr && (w_idx == REG_CAPACITY);
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_open <= 1'b1;
            r_cfg.capacity     <= CAP_RESET;
            r_cfg.max_message  <= MAXMSG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_CHANNEL_OPEN: r_cfg.channel_open <= pwdata[0];
                REG_CAPACITY:     r_cfg.capacity     <= pwdata[COUNT_W-1:0];
                REG_MAX_MESSAGE:  r_cfg.max_message  <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CHANNEL_OPEN: prdata = APB_DATA_W'(r_cfg.channel_open);
            REG_CAPACITY:     prdata = APB_DATA_W'(r_cfg.capacity);
            REG_MAX_MESSAGE:  prdata = APB_DATA_W'(r_cfg.max_message);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- hdl/mmf_ctrl.sv -----
module mmf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mmf_pkg::t_stat i_stat,
    output mmf_pkg::t_cmd  o_cmd
);
    import mmf_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_CHK  = 11'b000_0000_0010,
        S_HDRW = 11'b000_0000_0100,
        S_RH0  = 11'b000_0000_1000,
        S_RH1  = 11'b000_0001_0000,
        S_RH2  = 11'b000_0010_0000,
        S_RH3  = 11'b000_0100_0000,
        S_DEC  = 11'b000_1000_0000,
        S_SRD  = 11'b001_0000_0000,
        S_SWT  = 11'b010_0000_0000,
        S_RESP = 11'b100_0000_0000
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    w_consume;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_consume  = (i_stat.mode == MODE_RECEIVE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd        = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_RESP;
                case (i_stat.mode)
                    MODE_SEND_BEGIN: begin
                        if (i_stat.pend_active) begin
                            n_status = ST_IGNORED;
                        end else if (i_stat.len_zero) begin
                            n_status = ST_INVALID;
                        end else if (i_stat.closed) begin
                            n_status = ST_CLOSED;
                        end else if (i_stat.len_too_big) begin
                            n_status = ST_TOO_BIG;
                        end else if (i_stat.no_space) begin
                            n_status = ST_RETRY;
                        end else begin
                            o_cmd.hdr_start = 1'b1;
                            n_state         = S_HDRW;
                        end
                    end
                    MODE_SEND_DATA: begin
                        if (!i_stat.pend_active) begin
                            n_status = ST_IGNORED;
                        end else begin
                            o_cmd.data_write = 1'b1;
                            n_status         = ST_OK;
                        end
                    end
                    MODE_RECEIVE, MODE_PEEK: begin
                        if (i_stat.maxs_zero) begin
                            n_status = ST_INVALID;
                        end else if (w_consume && i_stat.closed) begin
                            n_status = ST_CLOSED;
                        end else if (i_stat.no_header) begin
                            n_status = w_consume ? ST_RETRY : ST_EMPTY;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = S_RH0;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_HDRW: begin
                o_cmd.hdr_write = 1'b1;
                if (i_stat.hdr_last) begin
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end
            end
            // The ring read is registered, so each header byte lands in the cycle after
            // its address; after the sender byte the address jumps to
            // the first body byte.
            S_RH0: begin
                o_cmd.rd_step = 1'b1;
                n_state       = S_RH1;
            end
            S_RH1: begin
                o_cmd.cap_len = 1'b1;
                o_cmd.rd_step = 1'b1;
                n_state       = S_RH2;
            end
            S_RH2: begin
                o_cmd.cap_snd = 1'b1;
                o_cmd.rd_jump = 1'b1;
                n_state       = S_RH3;
            end
            S_RH3: begin
                o_cmd.cap_flg = 1'b1;
                n_state       = S_DEC;
            end
            S_DEC: begin
                if (i_stat.body_too_big) begin
                    n_status = ST_TOO_BIG;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.consume = w_consume;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_SRD: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit_data = 1'b1;
                    if (i_stat.body_last) begin
                        o_cmd.rd_step = !i_stat.body_empty;
                        o_cmd.rp_load = w_consume;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.rd_step = 1'b1;
                        n_state       = S_SWT;
                    end
                end
            end
            S_SWT: begin
                n_state = S_SRD;
            end
            S_RESP: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- hdl/mmf_dp.sv -----
module mmf_dp #(
    parameter int BUFFER_BYTES = 256,
    parameter int HEADER_BYTES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mmf_pkg::t_cfg  i_cfg,
    input  logic           i_flush,
    input  mmf_pkg::t_cmd  i_cmd,
    output mmf_pkg::t_stat o_stat,
    input  logic           i_in_ready,
    mmf_in_if.sink         i_in,
    mmf_out_if.source      o_out
);
    import mmf_pkg::*;

    localparam int AW   = $clog2(BUFFER_BYTES);
    localparam int CAPW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam int SUMW = CAPW + 1;
    localparam int HW   = $clog2(HEADER_BYTES);

    logic [BYTE_W-1:0] r_mem [BUFFER_BYTES];

    // Latched request.
    t_mode             r_mode;
    logic [BYTE_W-1:0] r_len, r_snd, r_flg, r_dbyte, r_maxs;

    // Ring state.
    logic [AW-1:0]      r_wp, r_rp, r_rd_addr;
    logic [COUNT_W-1:0] r_count;
    logic [LEN_W-1:0]   r_pend_rem, r_pend_len;
    logic [HW-1:0]      r_hidx;
    logic [BYTE_W-1:0]  r_rd_data;

    // Header of the message being delivered.
    logic [LEN_W-1:0]  r_hlen, r_bcnt;
    logic [BYTE_W-1:0] r_hsnd, r_hflg;

    // Output register.
    logic               r_ovalid;
    t_status            r_o_status;
    logic [BYTE_W-1:0]  r_o_data, r_o_snd, r_o_flg;
    logic [LEN_W-1:0]   r_o_len;
    logic               r_o_last, r_o_rr, r_o_wr;
    logic [COUNT_W-1:0] r_o_used;

    logic [CAPW-1:0]    w_cap_raw, w_cap;
    logic [LEN_W-1:0]   w_maxm;
    logic [AW-1:0]      w_wp_inc, w_rd_inc, w_rd_jump, w_rd_next;
    logic [SUMW-1:0]    w_commit_sum, w_total;
    logic [COUNT_W-1:0] w_commit, w_after_read;
    logic [BYTE_W-1:0]  w_hdr_byte;
    logic               w_emit, w_slot_free, w_body_empty, w_body_last;

    function automatic logic [AW-1:0] f_wrap(input logic [SUMW-1:0] pos,
                                             input logic [CAPW-1:0] cap);
        logic [SUMW-1:0] v;
        v = pos;
        if (v >= {1'b0, cap}) begin
            v = v - {1'b0, cap};
        end
        return v[AW-1:0];
    endfunction

    // Capacity in use, held within 16 and the ring size.
    assign w_cap_raw = CAPW'(i_cfg.capacity);
    always_comb begin
        if (w_cap_raw < CAPW'(CAP_MIN)) begin
            w_cap = CAPW'(CAP_MIN);
        end else if (w_cap_raw > CAPW'(BUFFER_BYTES)) begin
            w_cap = CAPW'(BUFFER_BYTES);
        end else begin
            w_cap = w_cap_raw;
        end
    end

    assign w_maxm = (i_cfg.max_message > LEN_W'(BODY_LIMIT)) ? LEN_W'(BODY_LIMIT)
                                                              : i_cfg.max_message;

    assign w_wp_inc  = f_wrap(SUMW'(r_wp) + SUMW'(1), w_cap);
    assign w_rd_inc  = f_wrap(SUMW'(r_rd_addr) + SUMW'(1), w_cap);
    assign w_rd_jump = f_wrap(SUMW'(r_rp) + SUMW'(HEADER_BYTES), w_cap);
    assign w_rd_next = i_cmd.rd_step ? w_rd_inc : r_rd_addr;

    assign w_commit_sum = SUMW'(r_count) + SUMW'(HEADER_BYTES) + SUMW'(r_pend_len);
    assign w_commit     = (w_commit_sum > SUMW'(w_cap)) ? COUNT_W'(w_cap)
                                                        : COUNT_W'(w_commit_sum);
    assign w_total      = SUMW'(HEADER_BYTES) + SUMW'(r_hlen);
    assign w_after_read = (SUMW'(r_count) > w_total) ? COUNT_W'(SUMW'(r_count) - w_total)
                                                     : '0;

    always_comb begin
        case (r_hidx)
            HW'(0):  w_hdr_byte = r_len;
            HW'(1):  w_hdr_byte = r_snd;
            HW'(2):  w_hdr_byte = r_flg;
            default: w_hdr_byte = '0;
        endcase
    end

    assign w_slot_free  = !r_ovalid || o_out.ready;
    assign w_body_empty = (r_hlen == '0);
    assign w_body_last  = w_body_empty || (r_bcnt == (r_hlen - LEN_W'(1)));
    assign w_emit       = i_cmd.emit_status || i_cmd.emit_data;

    always_comb begin
        o_stat.mode         = r_mode;
        o_stat.pend_active  = (r_pend_rem != '0);
        o_stat.len_zero     = (r_len == '0);
        o_stat.closed       = !i_cfg.channel_open;
        o_stat.len_too_big  = (r_len > {1'b0, w_maxm});
        o_stat.no_space     = (SUMW'(r_count) + SUMW'(HEADER_BYTES) + SUMW'(r_len))
                              > SUMW'(w_cap);
        o_stat.maxs_zero    = (r_maxs == '0);
        o_stat.no_header    = (r_count < COUNT_W'(HEADER_BYTES));
        o_stat.body_too_big = ({1'b0, r_hlen} > r_maxs);
        o_stat.hdr_last     = (r_hidx == HW'(HEADER_BYTES - 1));
        o_stat.body_last    = w_body_last;
        o_stat.body_empty   = w_body_empty;
        o_stat.slot_free    = w_slot_free;
    end

    assign i_in.ready = i_in_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mode  <= t_mode'(i_in.mode);
            r_len   <= i_in.length;
            r_snd   <= i_in.sender_id;
            r_flg   <= i_in.msg_flags;
            r_dbyte <= i_in.data_byte;
            r_maxs  <= i_in.recv_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_count    <= '0;
            r_pend_rem <= '0;
            r_pend_len <= '0;
        end else begin
            if (i_cmd.hdr_start) begin
                r_pend_rem <= r_len[LEN_W-1:0];
                r_pend_len <= r_len[LEN_W-1:0];
            end
            if (i_cmd.hdr_write || i_cmd.data_write) begin
                r_wp <= w_wp_inc;
            end
            if (i_cmd.data_write) begin
                r_pend_rem <= r_pend_rem - LEN_W'(1);
                // The last body byte commits the whole message.
                if (r_pend_rem == LEN_W'(1)) begin
                    r_count    <= w_commit;
                    r_pend_len <= '0;
                end
            end
            if (i_cmd.consume) begin
                r_count <= w_after_read;
            end
            if (i_cmd.rp_load) begin
                r_rp <= w_rd_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx <= '0;
        end else if (i_cmd.hdr_start) begin
            r_hidx <= '0;
        end else if (i_cmd.hdr_write) begin
            r_hidx <= r_hidx + HW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr_write) begin
            r_mem[r_wp] <= w_hdr_byte;
        end else if (i_cmd.data_write) begin
            r_mem[r_wp] <= r_dbyte;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_addr <= r_rp;
        end else if (i_cmd.rd_jump) begin
            r_rd_addr <= w_rd_jump;
        end else begin
            r_rd_addr <= w_rd_next;
        end
        if (i_cmd.cap_len) begin
            r_hlen <= (r_rd_data > BYTE_W'(BODY_LIMIT)) ? LEN_W'(BODY_LIMIT)
                                                        : r_rd_data[LEN_W-1:0];
        end
        if (i_cmd.cap_snd) begin
            r_hsnd <= r_rd_data;
        end
        if (i_cmd.cap_flg) begin
            r_hflg <= r_rd_data;
        end
        if (i_cmd.cnt_clr) begin
            r_bcnt <= '0;
        end else if (i_cmd.emit_data) begin
            r_bcnt <= r_bcnt + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_rr   <= (r_count >= COUNT_W'(HEADER_BYTES));
            r_o_wr   <= (CAPW'(r_count) < (w_cap >> 1));
            r_o_used <= r_count;
            if (i_cmd.emit_data) begin
                r_o_status <= ST_OK;
                r_o_data   <= w_body_empty ? '0 : r_rd_data;
                r_o_len    <= r_hlen;
                r_o_snd    <= r_hsnd;
                r_o_flg    <= r_hflg;
                r_o_last   <= w_body_last;
            end else begin
                r_o_status <= i_cmd.status;
                r_o_data   <= '0;
                r_o_len    <= '0;
                r_o_snd    <= '0;
                r_o_flg    <= '0;
                r_o_last   <= 1'b1;
            end
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.status         = r_o_status;
    assign o_out.data_out       = r_o_data;
    assign o_out.message_length = r_o_len;
    assign o_out.sender_out     = r_o_snd;
    assign o_out.flags_out      = r_o_flg;
    assign o_out.last           = r_o_last;
    assign o_out.read_ready     = r_o_rr;
    assign o_out.write_ready    = r_o_wr;
    assign o_out.used_bytes     = r_o_used;

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CAPW'(r_count) <= w_cap)
        else $error("committed byte count exceeds the capacity in use");

    a_ptrs_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CAPW'(r_wp) < w_cap) && (CAPW'(r_rp) < w_cap))
        else $error("ring pointer outside the capacity in use");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_slot_free)
        else $error("result loaded while the output register is still full");

    a_data_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.data_write || i_cmd.hdr_write) |-> !(i_cmd.emit_data || i_cmd.rd_start))
        else $error("ring write overlaps a delivery");

endmodule

// ----- tb/tb_message_mailbox_fifo.sv -----
`timescale 1ns / 1ps

module tb_message_mailbox_fifo;
    import mmf_pkg::*;

    localparam int RING_BYTES     = 256;
    localparam int HDR_BYTES      = 8;
    localparam int REG_STRIDE     = 4;
    localparam int SETTLE_CYCLES  = 16;
    localparam int FINAL_DRAIN    = 2 * BODY_LIMIT + 12;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {
        REG_CHANNEL_OPEN = 0,
        REG_CAPACITY     = 1,
        REG_MAX_MESSAGE  = 2
    } t_mbx_reg;

    typedef struct {
        t_mode             mode;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] sender_id;
        logic [BYTE_W-1:0] msg_flags;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] recv_limit;
    } t_mbx_req;

    typedef struct {
        t_status            status;
        logic [BYTE_W-1:0]  data_out;
        logic [LEN_W-1:0]   message_length;
        logic [BYTE_W-1:0]  sender_out;
        logic [BYTE_W-1:0]  flags_out;
        logic               last;
        logic               read_ready;
        logic               write_ready;
        logic [COUNT_W-1:0] used_bytes;
    } t_mbx_result;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    mmf_in_if  in_if ();
    mmf_out_if out_if ();

    message_mailbox_fifo #(
        .BUFFER_BYTES(RING_BYTES),
        .HEADER_BYTES(HDR_BYTES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the mailbox: ring contents, pointers and register values.
    logic [BYTE_W-1:0] m_ring [RING_BYTES];
    int unsigned m_rd_ptr = 0;
    int unsigned m_wr_ptr = 0;
    int unsigned m_committed = 0;
    int unsigned m_pend_left = 0;
    int unsigned m_pend_len = 0;
    bit          cfg_open = 1'b1;
    int unsigned cfg_capacity = RING_BYTES;
    int unsigned cfg_max_msg = BODY_LIMIT;

    t_mbx_result expected_results [$];
    t_mbx_result got;
    int unsigned mismatch_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned stall_request = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned items_sent = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned ring_span();
        int unsigned c;
        c = cfg_capacity;
        if (c < CAP_MIN) c = CAP_MIN;
        if (c > RING_BYTES) c = RING_BYTES;
        return c;
    endfunction

    function automatic int unsigned body_cap();
        return (cfg_max_msg > BODY_LIMIT) ? BODY_LIMIT : cfg_max_msg;
    endfunction

    function automatic t_mbx_result blank_result(t_status st);
        t_mbx_result r;
        r.status         = st;
        r.data_out       = '0;
        r.message_length = '0;
        r.sender_out     = '0;
        r.flags_out      = '0;
        r.last           = 1'b1;
        r.read_ready     = 1'b0;
        r.write_ready    = 1'b0;
        r.used_bytes     = '0;
        return r;
    endfunction

    // Updates the mirror for one accepted request and queues its results.
    function automatic void apply_request(t_mbx_req r);
        t_mbx_result res [$];
        t_mbx_result one;
        int unsigned span;
        int unsigned len;
        int unsigned cnt;
        int unsigned total;
        int unsigned i;
        bit          consume;
        t_status     st;
        span = ring_span();
        st = ST_OK;
        case (r.mode)
            MODE_SEND_BEGIN: begin
                if (m_pend_left != 0) st = ST_IGNORED;
                else if (r.length == 0) st = ST_INVALID;
                else if (!cfg_open) st = ST_CLOSED;
                else if (r.length > body_cap()) st = ST_TOO_BIG;
                else if (m_committed + HDR_BYTES + r.length > span) st = ST_RETRY;
                else begin
                    for (i = 0; i < HDR_BYTES; i++) begin
                        m_ring[(m_wr_ptr + i) % span] = (i == 0) ? r.length :
                                                        (i == 1) ? r.sender_id :
                                                        (i == 2) ? r.msg_flags : 8'd0;
                    end
                    m_wr_ptr = (m_wr_ptr + HDR_BYTES) % span;
                    m_pend_left = 32'(r.length);
                    m_pend_len = 32'(r.length);
                end
                res.push_back(blank_result(st));
            end
            MODE_SEND_DATA: begin
                if (m_pend_left == 0) begin
                    st = ST_IGNORED;
                end else begin
                    m_ring[m_wr_ptr] = r.data_byte;
                    m_wr_ptr = (m_wr_ptr + 1) % span;
                    m_pend_left--;
                    if (m_pend_left == 0) begin
                        m_committed += HDR_BYTES + m_pend_len;
                        if (m_committed > span) m_committed = span;
                        m_pend_len = 0;
                    end
                end
                res.push_back(blank_result(st));
            end
            default: begin
                consume = (r.mode == MODE_RECEIVE);
                if (r.recv_limit == 0) begin
                    st = ST_INVALID;
                end else if (consume && !cfg_open) begin
                    st = ST_CLOSED;
                end else if (m_committed < HDR_BYTES) begin
                    st = consume ? ST_RETRY : ST_EMPTY;
                end else begin
                    len = 32'(m_ring[m_rd_ptr % span]);
                    if (len > BODY_LIMIT) len = BODY_LIMIT;
                    if (len > r.recv_limit) begin
                        st = ST_TOO_BIG;
                    end else begin
                        // A zero length header still yields one closing byte.
                        cnt = (len != 0) ? len : 1;
                        for (i = 0; i < cnt; i++) begin
                            one = blank_result(ST_OK);
                            one.data_out = (len != 0) ?
                                m_ring[(m_rd_ptr + HDR_BYTES + i) % span] : 8'd0;
                            one.message_length = LEN_W'(len);
                            one.sender_out = m_ring[(m_rd_ptr + 1) % span];
                            one.flags_out = m_ring[(m_rd_ptr + 2) % span];
                            one.last = (i + 1 == cnt);
                            res.push_back(one);
                        end
                        if (consume) begin
                            total = HDR_BYTES + len;
                            m_rd_ptr = (m_rd_ptr + total) % span;
                            m_committed = (m_committed > total) ? m_committed - total : 0;
                        end
                    end
                end
                if (res.size() == 0) res.push_back(blank_result(st));
            end
        endcase
        foreach (res[k]) begin
            res[k].read_ready = (m_committed >= HDR_BYTES);
            res[k].write_ready = (m_committed < span / 2);
            res[k].used_bytes = COUNT_W'(m_committed);
            expected_results.push_back(res[k]);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected, status %0d", out_if.status);
                mismatch_count++;
            end else begin
                got = expected_results.pop_front();
                check_field("status", 32'(got.status), 32'(out_if.status));
                check_field("data_out", 32'(got.data_out), 32'(out_if.data_out));
                check_field("message_length", 32'(got.message_length),
                            32'(out_if.message_length));
                check_field("sender_out", 32'(got.sender_out), 32'(out_if.sender_out));
                check_field("flags_out", 32'(got.flags_out), 32'(out_if.flags_out));
                check_field("last", 32'(got.last), 32'(out_if.last));
                check_field("read_ready", 32'(got.read_ready), 32'(out_if.read_ready));
                check_field("write_ready", 32'(got.write_ready), 32'(out_if.write_ready));
                check_field("used_bytes", 32'(got.used_bytes), 32'(out_if.used_bytes));
            end
        end
    end

    // Receiver side: random idling, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else begin
            out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("FAIL message_mailbox_fifo");
                $finish;
            end
        end
    end

    // Fields that the mode does not use are filled with random values.
    function automatic t_mbx_req req_of(t_mode mode, logic [BYTE_W-1:0] arg);
        t_mbx_req r;
        r.mode       = mode;
        r.length     = BYTE_W'($urandom_range(255));
        r.sender_id  = BYTE_W'($urandom_range(255));
        r.msg_flags  = BYTE_W'($urandom_range(255));
        r.data_byte  = BYTE_W'($urandom_range(255));
        r.recv_limit = BYTE_W'($urandom_range(255));
        case (mode)
            MODE_SEND_BEGIN: r.length = arg;
            MODE_SEND_DATA:  r.data_byte = arg;
            default:         r.recv_limit = arg;
        endcase
        return r;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_req(t_mbx_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.mode       <= r.mode;
        in_if.length     <= r.length;
        in_if.sender_id  <= r.sender_id;
        in_if.msg_flags  <= r.msg_flags;
        in_if.data_byte  <= r.data_byte;
        in_if.recv_limit <= r.recv_limit;
        do @(posedge i_clk); while (!in_if.ready);
        apply_request(r);
        items_sent++;
    endtask

    task automatic send_message(int unsigned len, int unsigned body_bytes);
        send_req(req_of(MODE_SEND_BEGIN, BYTE_W'(len)));
        repeat (body_bytes) send_req(req_of(MODE_SEND_DATA, BYTE_W'($urandom_range(255))));
    endtask

    // Sender pauses until every expected result has come, then lets the
    // controller finish whatever it still has in hand.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(t_mbx_reg idx, logic [APB_DATA_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ADDR_W'(idx * REG_STRIDE);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHANNEL_OPEN: cfg_open = value[0];
            REG_CAPACITY: begin
                cfg_capacity = 32'(value[COUNT_W-1:0]);
                m_rd_ptr = 0;
                m_wr_ptr = 0;
                m_committed = 0;
                m_pend_left = 0;
                m_pend_len = 0;
            end
            REG_MAX_MESSAGE: cfg_max_msg = 32'(value[LEN_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic test_reject_paths();
        send_req(req_of(MODE_SEND_BEGIN, 8'd0));
        send_req(req_of(MODE_RECEIVE, 8'd8));
        send_req(req_of(MODE_PEEK, 8'd8));
        send_req(req_of(MODE_RECEIVE, 8'd0));
        send_req(req_of(MODE_PEEK, 8'd0));
        send_req(req_of(MODE_SEND_DATA, 8'hA5));
        send_req(req_of(MODE_SEND_BEGIN, 8'd65));
        send_req(req_of(MODE_SEND_BEGIN, 8'd255));
    endtask

    task automatic test_basic_transfer();
        t_mbx_req r;
        r = req_of(MODE_SEND_BEGIN, 8'd1);
        r.sender_id = 8'hFF;
        r.msg_flags = 8'h00;
        send_req(r);
        send_req(req_of(MODE_SEND_DATA, 8'hFF));
        r = req_of(MODE_SEND_BEGIN, 8'd3);
        r.sender_id = 8'h00;
        r.msg_flags = 8'hFF;
        send_req(r);
        // A second begin while the body is still open is ignored.
        send_req(req_of(MODE_SEND_BEGIN, 8'd2));
        send_req(req_of(MODE_SEND_DATA, 8'h00));
        send_req(req_of(MODE_SEND_DATA, 8'h5A));
        send_req(req_of(MODE_SEND_DATA, 8'hC3));
        send_req(req_of(MODE_PEEK, 8'hFF));
        send_req(req_of(MODE_RECEIVE, 8'd1));
        send_req(req_of(MODE_PEEK, 8'd2));
        send_req(req_of(MODE_RECEIVE, 8'd2));
        send_req(req_of(MODE_RECEIVE, 8'hFF));
        send_req(req_of(MODE_RECEIVE, 8'hFF));
    endtask

    task automatic test_longest_message();
        send_message(BODY_LIMIT, BODY_LIMIT);
        send_req(req_of(MODE_PEEK, 8'(BODY_LIMIT)));
        send_req(req_of(MODE_RECEIVE, 8'(BODY_LIMIT - 1)));
        send_req(req_of(MODE_RECEIVE, 8'(BODY_LIMIT)));
    endtask

    task automatic test_channel_closed();
        send_message(2, 2);
        send_message(3, 1);
        reg_write(REG_CHANNEL_OPEN, 0);
        // Body bytes of a send admitted before closing are still taken.
        send_req(req_of(MODE_SEND_DATA, 8'h81));
        send_req(req_of(MODE_SEND_DATA, 8'h7E));
        send_req(req_of(MODE_SEND_BEGIN, 8'd1));
        send_req(req_of(MODE_SEND_BEGIN, 8'd0));
        send_req(req_of(MODE_RECEIVE, 8'hFF));
        send_req(req_of(MODE_RECEIVE, 8'd0));
        send_req(req_of(MODE_PEEK, 8'hFF));
        reg_write(REG_CHANNEL_OPEN, 1);
        send_req(req_of(MODE_RECEIVE, 8'hFF));
        send_req(req_of(MODE_RECEIVE, 8'hFF));
    endtask

    task automatic test_capacity_limits();
        reg_write(REG_CAPACITY, CAP_MIN);
        send_message(HDR_BYTES, HDR_BYTES);
        send_req(req_of(MODE_SEND_BEGIN, 8'd1));
        send_req(req_of(MODE_PEEK, 8'hFF));
        send_req(req_of(MODE_RECEIVE, 8'hFF));
        // Three short messages walk the pointers around the smallest ring.
        repeat (3) begin
            send_message(3, 3);
            send_req(req_of(MODE_RECEIVE, 8'hFF));
        end
        send_message(4, 2);
        // Below the minimum saturates; the open send is abandoned.
        reg_write(REG_CAPACITY, 5);
        send_req(req_of(MODE_SEND_DATA, 8'h3C));
        send_req(req_of(MODE_RECEIVE, 8'hFF));
        reg_write(REG_CAPACITY, 400);
        reg_write(REG_MAX_MESSAGE, 0);
        send_req(req_of(MODE_SEND_BEGIN, 8'd1));
        reg_write(REG_MAX_MESSAGE, 127);
        send_req(req_of(MODE_SEND_BEGIN, 8'd65));
        reg_write(REG_MAX_MESSAGE, 1);
        send_message(1, 1);
        send_req(req_of(MODE_SEND_BEGIN, 8'd2));
        send_req(req_of(MODE_RECEIVE, 8'hFF));
        reg_write(REG_MAX_MESSAGE, BODY_LIMIT);
        reg_write(REG_CAPACITY, RING_BYTES);
    endtask

    task automatic test_backpressure();
        settle();
        stall_request = 300;
        repeat (6) begin
            send_message(3, 3);
            send_req(req_of(MODE_PEEK, 8'hFF));
        end
        repeat (6) send_req(req_of(MODE_RECEIVE, 8'hFF));
        settle();
    endtask

    function automatic int unsigned pick_length(int unsigned maxm);
        int unsigned p;
        p = $urandom_range(99);
        if (maxm == 0) return 1;
        if (p < 70) return $urandom_range(1, (maxm < 12) ? maxm : 12);
        if (p < 85) return maxm;
        return $urandom_range(1, maxm);
    endfunction

    task automatic random_sequence();
        int unsigned pick;
        int unsigned len;
        int unsigned left;
        t_mbx_req r;
        pick = $urandom_range(99);
        if (pick < 40) begin
            left = m_pend_left;
            repeat (left) send_req(req_of(MODE_SEND_DATA, BYTE_W'($urandom_range(255))));
            len = pick_length(body_cap());
            while (m_committed >= HDR_BYTES && m_committed + HDR_BYTES + len > ring_span())
                send_req(req_of(MODE_RECEIVE, 8'hFF));
            send_message(len, len);
        end else if (pick < 65) begin
            send_req(req_of(MODE_RECEIVE, ($urandom_range(99) < 80) ?
                            8'hFF : BYTE_W'($urandom_range(255))));
        end else if (pick < 77) begin
            send_req(req_of(MODE_PEEK, ($urandom_range(99) < 80) ?
                            8'hFF : BYTE_W'($urandom_range(255))));
        end else if (pick < 85) begin
            // Broken sequence: the body stops short of its length.
            len = pick_length(body_cap());
            send_message(len, $urandom_range(0, len - 1));
        end else begin
            r = req_of(t_mode'($urandom_range(3)), BYTE_W'($urandom_range(255)));
            send_req(r);
        end
    endtask

    task automatic run_random_phase(int unsigned count, int unsigned src_pct,
                                    int unsigned sink_pct);
        int unsigned stop_at;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at) random_sequence();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_if.valid      <= 1'b0;
        in_if.mode       <= MODE_SEND_BEGIN;
        in_if.length     <= '0;
        in_if.sender_id  <= '0;
        in_if.msg_flags  <= '0;
        in_if.data_byte  <= '0;
        in_if.recv_limit <= '0;
        src_idle_pct = 20;
        sink_idle_pct = 66;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reject_paths();
        test_basic_transfer();
        test_longest_message();
        test_channel_closed();
        test_capacity_limits();
        test_backpressure();

        run_random_phase(60, 20, 66);
        reg_write(REG_CAPACITY, 100);
        reg_write(REG_MAX_MESSAGE, 20);
        run_random_phase(60, 66, 20);
        reg_write(REG_CAPACITY, 400);
        reg_write(REG_MAX_MESSAGE, 127);
        run_random_phase(60, 0, 0);

        settle();
        repeat (FINAL_DRAIN) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS message_mailbox_fifo");
        end else begin
            $display("FAIL message_mailbox_fifo");
        end
        $finish;
    end

endmodule
